/* rtl/bchd_pkg.sv */
// ----------------------------------------------------------------------------
// bchd_pkg: shared types, constants and GF(64) arithmetic
// Field polynomial x^6+x+1, exponent/log tables built at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package bchd_pkg;

	localparam int CW_LEN     = 63;
	localparam int NSYN       = 22;
	localparam int MAX_ERRORS = 11;
	localparam int DATA_W     = 16;
	localparam int DATA_LSB   = 47;

	localparam logic [6:0] GF_POLY = 7'h43;

	typedef logic [5:0]                 gf_t;
	typedef logic [63:0][5:0]           gf_tab_t;
	typedef logic [MAX_ERRORS:0][5:0]   poly_t;
	typedef logic [NSYN-1:0][5:0]       syn_t;

	typedef struct packed {
		logic clr;
		logic en;
	} syn_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SYN,
		ST_CHECK,
		ST_FACT,
		ST_UPD,
		ST_COMMIT,
		ST_DINIT,
		ST_DISC,
		ST_CLOAD,
		ST_CHIEN,
		ST_CEND,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_ROOTS  = 2'd1,
		STS_DEGREE = 2'd2
	} status_t;

	function automatic gf_t gf_mul(input gf_t a, input gf_t b);
		logic [10:0] p;
		p = '0;
		for (int i = 0; i < 6; i++) begin
			if (b[i]) p = p ^ ({5'b0, a} << i);
		end
		for (int i = 10; i >= 6; i--) begin
			if (p[i]) p = p ^ ({4'b0, GF_POLY} << (i - 6));
		end
		return p[5:0];
	endfunction

	function automatic gf_tab_t build_exp();
		gf_tab_t t;
		logic [6:0] v;
		t = '0;
		v = 7'd1;
		for (int k = 0; k < 63; k++) begin
			t[k] = v[5:0];
			v = v << 1;
			if (v[6]) v = v ^ GF_POLY;
		end
		t[63] = '0;
		return t;
	endfunction

	function automatic gf_tab_t build_log();
		gf_tab_t t;
		gf_tab_t e;
		t = '0;
		e = build_exp();
		for (int k = 0; k < 63; k++) begin
			t[e[k]] = 6'(k);
		end
		return t;
	endfunction

	localparam gf_tab_t GF_EXP = build_exp();
	localparam gf_tab_t GF_LOG = build_log();

endpackage

`default_nettype wire

/* rtl/bch_63_16_decoder_top.sv */
// ----------------------------------------------------------------------------
// bch_63_16_decoder_top: BCH(63,16) decoder
// Syndromes, Berlekamp iteration on one shared GF multiplier, Chien search.
// ----------------------------------------------------------------------------
//  channel  signals                                   dir
//  in       in_valid, in_ready, codeword[62:0]        sink
//  out      out_valid, out_ready, data_word[15:0],    source
//           corrected_count[3:0], status[1:0]
//
//  A clean word goes from the syndromes straight to the output. Otherwise
//  each of the 22 Berlekamp steps updates the locator if the discrepancy is
//  nonzero; the next discrepancy is formed after each of the first 21 steps,
//  then the Chien search runs. A degree above 11 goes straight to the output.
//  One item at a time; in_ready is high only in idle. A result waits in the
//  output register while the next transfer is taken. Reset clears control.
// ----------------------------------------------------------------------------
`default_nettype none

module bch_63_16_decoder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [62:0] codeword,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      data_word,
	output logic [3:0]       corrected_count,
	output logic [1:0]       status
);

	bchd_pkg::state_t   state_q, state_d;
	bchd_pkg::syn_ctl_t syn_ctl;
	bchd_pkg::syn_t     syn;

	logic [62:0]        cw_q;
	logic [5:0]         bit_q;
	logic [4:0]         step_q;
	logic [3:0]         k_q;
	logic [3:0]         deg_q, degn_q, bdeg_q;
	logic signed [5:0]  gap_q, bgap_q;
	logic [4:0]         bidx_q;
	bchd_pkg::gf_t      disc_q, bdisc_q, fact_q, acc_q;
	bchd_pkg::poly_t    cur_q, nxt_q, best_q, chr_q;
	logic [5:0]         n_q, roots_q;
	logic [15:0]        mask_q;
	logic [15:0]        res_data_q;
	logic [3:0]         res_cnt_q;
	bchd_pkg::status_t  res_sts_q;
	logic               out_valid_q;
	logic [15:0]        out_data_q;
	logic [3:0]         out_cnt_q;
	bchd_pkg::status_t  out_sts_q;

	logic [4:0]         shift;
	logic [5:0]         degb_sh, deg_n;
	logic               deg_big;
	logic [6:0]         log_diff;
	logic [5:0]         fidx;
	logic [5:0]         kd;
	logic               upd_hit, disc_hit;
	logic [4:0]         syn_addr;
	bchd_pkg::gf_t      syn_rd;
	bchd_pkg::gf_t      mul_a, mul_b, mul_p;
	bchd_pkg::poly_t    chn;
	bchd_pkg::gf_t      ch_sum;
	logic               syn_any;
	logic               out_free;

	bchd_syn u_syn (
		.clk (clk),
		.ctl (syn_ctl),
		.din (cw_q[bit_q]),
		.syn (syn)
	);

	assign syn_ctl.clr = (state_q == bchd_pkg::ST_IDLE) && in_valid;
	assign syn_ctl.en  = (state_q == bchd_pkg::ST_SYN);
	assign syn_any     = |syn;
	assign in_ready    = (state_q == bchd_pkg::ST_IDLE);
	assign out_free    = !out_valid_q || out_ready;

	assign shift    = step_q - bidx_q;
	assign degb_sh  = 6'(bdeg_q) + 6'(shift);
	assign deg_n    = (6'(deg_q) > degb_sh) ? 6'(deg_q) : degb_sh;
	assign deg_big  = (disc_q != '0) && (deg_n > 6'(bchd_pkg::MAX_ERRORS));
	assign log_diff = {1'b0, bchd_pkg::GF_LOG[disc_q]} - {1'b0, bchd_pkg::GF_LOG[bdisc_q]};
	assign fidx     = log_diff[6] ? 6'(log_diff + 7'd63) : log_diff[5:0];

	assign kd       = 6'(k_q) - 6'(shift);
	assign upd_hit  = {1'b0, k_q} >= shift;
	assign disc_hit = {1'b0, k_q} <= step_q;
	assign syn_addr = (state_q == bchd_pkg::ST_DINIT) ? step_q : step_q - 5'(k_q);
	assign syn_rd   = syn[syn_addr];

	always_comb begin
		if (state_q == bchd_pkg::ST_UPD) begin
			mul_a = fact_q;
			mul_b = upd_hit ? best_q[kd[3:0]] : '0;
		end else begin
			mul_a = syn_rd;
			mul_b = disc_hit ? cur_q[k_q] : '0;
		end
	end

	assign mul_p = bchd_pkg::gf_mul(mul_a, mul_b);

	always_comb begin
		chn    = '0;
		ch_sum = 6'd1;
		for (int m = 1; m <= bchd_pkg::MAX_ERRORS; m++) begin
			chn[m] = bchd_pkg::gf_mul(chr_q[m], bchd_pkg::GF_EXP[m]);
			ch_sum = ch_sum ^ chn[m];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bchd_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bchd_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bchd_pkg::ST_IDLE: begin
				if (in_valid) state_d = bchd_pkg::ST_SYN;
			end
			bchd_pkg::ST_SYN: begin
				if (bit_q == 6'(bchd_pkg::CW_LEN - 1)) state_d = bchd_pkg::ST_CHECK;
			end
			bchd_pkg::ST_CHECK: begin
				state_d = syn_any ? bchd_pkg::ST_FACT : bchd_pkg::ST_OUT;
			end
			bchd_pkg::ST_FACT: begin
				if (deg_big) state_d = bchd_pkg::ST_OUT;
				else if (disc_q == '0) state_d = bchd_pkg::ST_COMMIT;
				else state_d = bchd_pkg::ST_UPD;
			end
			bchd_pkg::ST_UPD: begin
				if (k_q == degn_q) state_d = bchd_pkg::ST_COMMIT;
			end
			bchd_pkg::ST_COMMIT: begin
				state_d = (step_q == 5'(bchd_pkg::NSYN)) ? bchd_pkg::ST_CLOAD
				                                         : bchd_pkg::ST_DINIT;
			end
			bchd_pkg::ST_DINIT: begin
				state_d = (deg_q == '0) ? bchd_pkg::ST_FACT : bchd_pkg::ST_DISC;
			end
			bchd_pkg::ST_DISC: begin
				if (k_q == deg_q) state_d = bchd_pkg::ST_FACT;
			end
			bchd_pkg::ST_CLOAD: begin
				state_d = bchd_pkg::ST_CHIEN;
			end
			bchd_pkg::ST_CHIEN: begin
				if (n_q == 6'(bchd_pkg::CW_LEN)) state_d = bchd_pkg::ST_CEND;
			end
			bchd_pkg::ST_CEND: begin
				state_d = bchd_pkg::ST_OUT;
			end
			bchd_pkg::ST_OUT: begin
				if (out_free) state_d = bchd_pkg::ST_IDLE;
			end
			default: state_d = bchd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bchd_pkg::ST_IDLE: begin
				if (in_valid) begin
					cw_q  <= codeword;
					bit_q <= '0;
				end
			end
			bchd_pkg::ST_SYN: begin
				bit_q <= bit_q + 6'd1;
			end
			bchd_pkg::ST_CHECK: begin
				res_data_q <= cw_q[62:bchd_pkg::DATA_LSB];
				res_cnt_q  <= '0;
				res_sts_q  <= bchd_pkg::STS_OK;
				step_q     <= 5'd1;
				disc_q     <= syn[0];
				deg_q      <= '0;
				gap_q      <= '0;
				cur_q      <= bchd_pkg::poly_t'(6'd1);
				best_q     <= bchd_pkg::poly_t'(6'd1);
				bdeg_q     <= '0;
				bdisc_q    <= 6'd1;
				bgap_q     <= -6'sd1;
				bidx_q     <= '0;
			end
			bchd_pkg::ST_FACT: begin
				degn_q <= (disc_q == '0) ? deg_q : deg_n[3:0];
				fact_q <= bchd_pkg::GF_EXP[fidx];
				k_q    <= '0;
				if (deg_big) begin
					res_data_q <= cw_q[62:bchd_pkg::DATA_LSB];
					res_cnt_q  <= '0;
					res_sts_q  <= bchd_pkg::STS_DEGREE;
				end
			end
			bchd_pkg::ST_UPD: begin
				nxt_q[k_q] <= cur_q[k_q] ^ mul_p;
				k_q        <= k_q + 4'd1;
			end
			bchd_pkg::ST_COMMIT: begin
				if (disc_q != '0) begin
					for (int i = 0; i <= bchd_pkg::MAX_ERRORS; i++) begin
						cur_q[i] <= (4'(i) <= degn_q) ? nxt_q[i] : '0;
					end
					if (gap_q >= bgap_q) begin
						best_q  <= cur_q;
						bdeg_q  <= deg_q;
						bdisc_q <= disc_q;
						bgap_q  <= gap_q;
						bidx_q  <= step_q;
					end
				end
				deg_q <= degn_q;
				gap_q <= $signed(6'(step_q) - 6'(degn_q));
			end
			bchd_pkg::ST_DINIT: begin
				if (deg_q == '0) begin
					disc_q <= syn_rd;
					step_q <= step_q + 5'd1;
				end else begin
					acc_q <= syn_rd;
					k_q   <= 4'd1;
				end
			end
			bchd_pkg::ST_DISC: begin
				if (k_q == deg_q) begin
					disc_q <= acc_q ^ mul_p;
					step_q <= step_q + 5'd1;
				end else begin
					acc_q <= acc_q ^ mul_p;
					k_q   <= k_q + 4'd1;
				end
			end
			bchd_pkg::ST_CLOAD: begin
				chr_q   <= cur_q;
				n_q     <= 6'd1;
				roots_q <= '0;
				mask_q  <= '0;
			end
			bchd_pkg::ST_CHIEN: begin
				for (int m = 1; m <= bchd_pkg::MAX_ERRORS; m++) begin
					chr_q[m] <= chn[m];
				end
				n_q <= n_q + 6'd1;
				if (ch_sum == '0) begin
					roots_q <= roots_q + 6'd1;
					if (n_q >= 6'(bchd_pkg::DATA_LSB + 1)) begin
						mask_q[4'(n_q - 6'(bchd_pkg::DATA_LSB + 1))] <= 1'b1;
					end
				end
			end
			bchd_pkg::ST_CEND: begin
				if (roots_q == 6'(deg_q)) begin
					res_data_q <= cw_q[62:bchd_pkg::DATA_LSB] ^ mask_q;
					res_cnt_q  <= deg_q;
					res_sts_q  <= bchd_pkg::STS_OK;
				end else begin
					res_data_q <= cw_q[62:bchd_pkg::DATA_LSB];
					res_cnt_q  <= '0;
					res_sts_q  <= bchd_pkg::STS_ROOTS;
				end
			end
			bchd_pkg::ST_OUT: begin
				if (out_free) begin
					out_data_q <= res_data_q;
					out_cnt_q  <= res_cnt_q;
					out_sts_q  <= res_sts_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid       = out_valid_q;
	assign data_word       = out_data_q;
	assign corrected_count = out_cnt_q;
	assign status          = out_sts_q;

endmodule

`default_nettype wire

/* rtl/bchd_syn.sv */
// ----------------------------------------------------------------------------
// bchd_syn: syndrome lanes
// Horner evaluation of S1..S22, one codeword bit per cycle, bit 0 first.
// ----------------------------------------------------------------------------
`default_nettype none

module bchd_syn (
	input  wire logic               clk,
	input  wire bchd_pkg::syn_ctl_t ctl,
	input  wire logic               din,
	output bchd_pkg::syn_t          syn
);

	bchd_pkg::syn_t acc_q;

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.en) begin
			for (int n = 0; n < bchd_pkg::NSYN; n++) begin
				acc_q[n] <= bchd_pkg::gf_mul(acc_q[n], bchd_pkg::GF_EXP[n + 1]) ^ {5'b0, din};
			end
		end
	end

	assign syn = acc_q;

endmodule

`default_nettype wire
